### sv/bdpc_pkg.sv
// ----------------------------------------------------------------------------
// bdpc_pkg
// Shared constants and types of the button debounce and press classifier.
// ----------------------------------------------------------------------------
`default_nettype none

package bdpc_pkg;

    localparam int NUM_BUTTONS = 7;
    localparam int IDX_W       = $clog2(NUM_BUTTONS);
    localparam int CFG_IDX_W   = 4;

    localparam logic [15:0] DEBOUNCE_RESET  = 16'd30;
    localparam logic [15:0] ONE_TOUCH_RESET = 16'd250;

    localparam logic [CFG_IDX_W-1:0] CFG_DEBOUNCE  = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] CFG_ONE_TOUCH = CFG_IDX_W'(1);

    localparam logic [2:0] BTN_DRV_OPEN    = 3'd0;
    localparam logic [2:0] BTN_DRV_CLOSE   = 3'd1;
    localparam logic [2:0] BTN_SEC_OPEN    = 3'd2;
    localparam logic [2:0] BTN_SEC_CLOSE   = 3'd3;
    localparam logic [2:0] BTN_LIM_OPEN    = 3'd4;
    localparam logic [2:0] BTN_LIM_CLOSED  = 3'd5;
    localparam logic [2:0] BTN_OBSTACLE    = 3'd6;

    localparam logic [3:0] EV_CONFLICT    = 4'd0;
    localparam logic [3:0] EV_OPEN_PRESS  = 4'd1;
    localparam logic [3:0] EV_CLOSE_PRESS = 4'd2;
    localparam logic [3:0] EV_OPEN_REL    = 4'd3;
    localparam logic [3:0] EV_CLOSE_REL   = 4'd4;
    localparam logic [3:0] EV_OPEN_AUTO   = 4'd5;
    localparam logic [3:0] EV_CLOSE_AUTO  = 4'd6;
    localparam logic [3:0] EV_LIM_OPEN    = 4'd7;
    localparam logic [3:0] EV_LIM_CLOSED  = 4'd8;
    localparam logic [3:0] EV_OBSTACLE    = 4'd9;

    localparam logic [1:0] SRC_NONE = 2'd0;
    localparam logic [1:0] SRC_DRV  = 2'd1;
    localparam logic [1:0] SRC_SEC  = 2'd2;

    typedef struct packed {
        logic [3:0]  event_code;
        logic [1:0]  event_source;
        logic [31:0] event_tick;
        logic        last_of_run;
    } event_t;

    typedef struct packed {
        logic [1:0] n;
        event_t     ev0;
        event_t     ev1;
    } cls_res_t;

endpackage

`default_nettype wire

### sv/button_debounce_press_classifier.sv
// ----------------------------------------------------------------------------
// button_debounce_press_classifier
// Debounces timestamped button edges and classifies them into gate events.
// ----------------------------------------------------------------------------
// Input channel s_*: one button edge per item (button, asserted, tick).
// Result channel m_*: gate events; each input item gives zero, one or two,
// the final one flagged by m_last_of_run.
// Configuration channel cfg_*: index 0 debounce ticks, index 1 one-touch
// limit; cfg_ready is always high, unknown indexes are dropped.
// The first event of an item is offered once the item has passed the input
// register and then the result register.
// Throughput: one item per cycle when each gives at most one event and the
// result side is not stalled; an item with two events holds the single
// result port until both have drained. Items that give no event leave the
// input register even while the result side is stalled.
// Reset (aresetn low, synchronous) clears all debounce timestamps, press
// ticks and held flags, empties both registers and restores the register
// defaults of 30 and 250 ticks.
// While m_ready is low the events wait in the result register; s_ready drops
// once the input register also holds an item that yields events.
// ----------------------------------------------------------------------------
`default_nettype none

module button_debounce_press_classifier
    import bdpc_pkg::*;
(
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 s_valid,
    output logic                      s_ready,
    input  wire logic [2:0]           s_button,
    input  wire logic                 s_asserted,
    input  wire logic [31:0]          s_tick,
    output logic                      m_valid,
    input  wire logic                 m_ready,
    output logic [3:0]                m_event_code,
    output logic [1:0]                m_event_source,
    output logic [31:0]               m_event_tick,
    output logic                      m_last_of_run,
    input  wire logic                 cfg_valid,
    output logic                      cfg_ready,
    input  wire logic [CFG_IDX_W-1:0] cfg_index,
    input  wire logic [15:0]          cfg_data
);

    logic        in_vld_reg;
    logic [2:0]  in_button_reg;
    logic        in_asserted_reg;
    logic [31:0] in_tick_reg;
    logic [15:0] debounce_reg;
    logic [15:0] one_touch_reg;

    cls_res_t res;
    event_t   head;
    logic     can_load;
    logic     move;
    logic     load;

    assign move      = in_vld_reg && ((res.n == 2'd0) || can_load);
    assign load      = move && (res.n != 2'd0);
    assign s_ready   = !in_vld_reg || move;
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            debounce_reg  <= DEBOUNCE_RESET;
            one_touch_reg <= ONE_TOUCH_RESET;
        end else if (cfg_valid) begin
            unique case (cfg_index)
                CFG_DEBOUNCE:  debounce_reg  <= cfg_data;
                CFG_ONE_TOUCH: one_touch_reg <= cfg_data;
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_vld_reg <= 1'b0;
        end else if (s_ready) begin
            in_vld_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_button_reg   <= s_button;
            in_asserted_reg <= s_asserted;
            in_tick_reg     <= s_tick;
        end
    end

    bdpc_classify u_classify (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .upd           (move),
        .button        (in_button_reg),
        .asserted      (in_asserted_reg),
        .tick          (in_tick_reg),
        .dbnc_min_ticks(debounce_reg),
        .auto_max_ticks(one_touch_reg),
        .res           (res)
    );

    bdpc_out_buf u_out_buf (
        .aclk    (aclk),
        .aresetn (aresetn),
        .load    (load),
        .res     (res),
        .can_load(can_load),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .head    (head)
    );

    assign m_event_code   = head.event_code;
    assign m_event_source = head.event_source;
    assign m_event_tick   = head.event_tick;
    assign m_last_of_run  = head.last_of_run;

`ifndef ASSERT_OFF
    a_load_shows: assert property (@(posedge aclk) disable iff (!aresetn)
        load |=> m_valid)
        else $error("loaded events not offered");

    a_two_last: assert property (@(posedge aclk) disable iff (!aresetn)
        in_vld_reg && (res.n == 2'd2) |-> res.ev1.last_of_run && !res.ev0.last_of_run)
        else $error("last_of_run misplaced on a two-event item");

    a_hold_in: assert property (@(posedge aclk) disable iff (!aresetn)
        in_vld_reg && !move |=> in_vld_reg && $stable(in_tick_reg))
        else $error("held input item lost");
`endif

endmodule

`default_nettype wire

### sv/bdpc_classify.sv
// ----------------------------------------------------------------------------
// bdpc_classify
// Per-button debounce state, press tracking and event classification.
// ----------------------------------------------------------------------------
`default_nettype none

module bdpc_classify
    import bdpc_pkg::*;
(
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        upd,
    input  wire logic [2:0]  button,
    input  wire logic        asserted,
    input  wire logic [31:0] tick,
    input  wire logic [15:0] dbnc_min_ticks,
    input  wire logic [15:0] auto_max_ticks,
    output cls_res_t         res
);

    logic [31:0] last_tick_reg [NUM_BUTTONS];
    logic [31:0] press_tick_reg [4];
    logic [3:0]  held_reg;

    logic [IDX_W-1:0] idx;
    logic [1:0]       cmd_idx;
    logic             in_range;
    logic             accept;
    logic             is_cmd;
    logic [31:0]      since_last;
    logic [31:0]      hold_time;

    assign idx        = IDX_W'(button);
    assign cmd_idx    = button[1:0];
    assign in_range   = 32'(button) < 32'(NUM_BUTTONS);
    assign since_last = tick - last_tick_reg[idx];
    assign accept     = in_range && (since_last >= {16'b0, dbnc_min_ticks});
    assign is_cmd     = button < BTN_LIM_OPEN;
    assign hold_time  = tick - press_tick_reg[cmd_idx];

    always_comb begin
        logic [3:0] held_now;
        logic       conflict;
        logic       is_open;
        logic [1:0] src;
        event_t     ev;
        held_now          = held_reg;
        held_now[cmd_idx] = 1'b1;
        conflict          = (held_now[0] | held_now[2]) & (held_now[1] | held_now[3]);
        is_open           = ~button[0];
        src               = button[1] ? SRC_SEC : SRC_DRV;
        ev.event_code     = EV_CONFLICT;
        ev.event_source   = SRC_NONE;
        ev.event_tick     = tick;
        ev.last_of_run    = 1'b0;
        res.n             = 2'd0;
        res.ev0           = ev;
        res.ev1           = ev;
        if (accept) begin
            if (is_cmd) begin
                if (asserted) begin
                    ev.event_code   = is_open ? EV_OPEN_PRESS : EV_CLOSE_PRESS;
                    ev.event_source = src;
                    ev.last_of_run  = 1'b1;
                    if (conflict) begin
                        res.n   = 2'd2;
                        res.ev1 = ev;
                    end else begin
                        res.n   = 2'd1;
                        res.ev0 = ev;
                    end
                end else begin
                    res.ev0.event_code   = is_open ? EV_OPEN_REL : EV_CLOSE_REL;
                    res.ev0.event_source = src;
                    res.ev1.event_code   = is_open ? EV_OPEN_AUTO : EV_CLOSE_AUTO;
                    res.ev1.event_source = src;
                    res.ev1.last_of_run  = 1'b1;
                    if (hold_time <= {16'b0, auto_max_ticks}) begin
                        res.n = 2'd2;
                    end else begin
                        res.n                   = 2'd1;
                        res.ev0.last_of_run     = 1'b1;
                    end
                end
            end else if (asserted) begin
                res.ev0.last_of_run = 1'b1;
                unique case (button)
                    BTN_LIM_OPEN: begin
                        res.n              = 2'd1;
                        res.ev0.event_code = EV_LIM_OPEN;
                    end
                    BTN_LIM_CLOSED: begin
                        res.n              = 2'd1;
                        res.ev0.event_code = EV_LIM_CLOSED;
                    end
                    BTN_OBSTACLE: begin
                        res.n              = 2'd1;
                        res.ev0.event_code = EV_OBSTACLE;
                    end
                    default: begin
                        res.n = 2'd0;
                    end
                endcase
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < NUM_BUTTONS; i++) begin
                last_tick_reg[i] <= '0;
            end
            for (int i = 0; i < 4; i++) begin
                press_tick_reg[i] <= '0;
            end
            held_reg <= '0;
        end else if (upd && accept) begin
            last_tick_reg[idx] <= tick;
            if (is_cmd) begin
                held_reg[cmd_idx] <= asserted;
                if (asserted) begin
                    press_tick_reg[cmd_idx] <= tick;
                end
            end
        end
    end

endmodule

`default_nettype wire

### sv/bdpc_out_buf.sv
// ----------------------------------------------------------------------------
// bdpc_out_buf
// Two-slot result register; loads all events of one item, drains one a cycle while m_ready is high.
// ----------------------------------------------------------------------------
`default_nettype none

module bdpc_out_buf
    import bdpc_pkg::*;
(
    input  wire logic     aclk,
    input  wire logic     aresetn,
    input  wire logic     load,
    input  wire cls_res_t res,
    output logic          can_load,
    output logic          m_valid,
    input  wire logic     m_ready,
    output event_t        head
);

    event_t     slot0_reg;
    event_t     slot1_reg;
    logic [1:0] cnt_reg;
    logic [1:0] cnt_next;
    logic       pop;

    assign m_valid  = cnt_reg != 2'd0;
    assign pop      = m_valid && m_ready;
    assign can_load = (cnt_reg == 2'd0) || ((cnt_reg == 2'd1) && pop);
    assign head     = slot0_reg;

    always_comb begin
        cnt_next = cnt_reg;
        if (load) begin
            cnt_next = res.n;
        end else if (pop) begin
            cnt_next = cnt_reg - 2'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg <= '0;
        end else begin
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            slot0_reg <= res.ev0;
            slot1_reg <= res.ev1;
        end else if (pop) begin
            slot0_reg <= slot1_reg;
        end
    end

endmodule

`default_nettype wire

### tb/sv/bdpc_event_checker.sv
// ----------------------------------------------------------------------------
// bdpc_event_checker
// Watches the edge, event and register channels of the classifier, predicts
// the gate events of every accepted edge and compares them in order.
// ----------------------------------------------------------------------------
// Keeps its own debounce timestamps, press ticks, held flags and register
// copies. Each accepted event is checked field by field against the oldest
// prediction; an event with none pending is a failure as well.
// ----------------------------------------------------------------------------
`default_nettype none

module bdpc_event_checker
    import bdpc_pkg::*;
(
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 s_valid,
    input  wire logic                 s_ready,
    input  wire logic [2:0]           s_button,
    input  wire logic                 s_asserted,
    input  wire logic [31:0]          s_tick,
    input  wire logic                 m_valid,
    input  wire logic                 m_ready,
    input  wire logic [3:0]           m_event_code,
    input  wire logic [1:0]           m_event_source,
    input  wire logic [31:0]          m_event_tick,
    input  wire logic                 m_last_of_run,
    input  wire logic                 cfg_valid,
    input  wire logic                 cfg_ready,
    input  wire logic [CFG_IDX_W-1:0] cfg_index,
    input  wire logic [15:0]          cfg_data,
    output int                        fail_count,
    output int                        events_due,
    output int                        events_checked,
    output int                        edges_kept
);

    localparam logic [3:0] OPEN_MASK  = 4'b0101;
    localparam logic [3:0] CLOSE_MASK = 4'b1010;

    logic [31:0] last_edge_tick [NUM_BUTTONS];
    logic [31:0] press_tick [4];
    logic [3:0]  held;
    logic [15:0] debounce_cfg;
    logic [15:0] one_touch_cfg;
    event_t      pending_events [$];

    task automatic report_mismatch(input string msg);
        $display("%0t: %s", $time, msg);
        fail_count++;
    endtask

    task automatic classify_edge(input logic [2:0] btn, input logic pressed,
                                 input logic [31:0] tick);
        event_t      evs [2];
        int          n;
        logic [1:0]  src;
        logic        is_open;
        logic [31:0] elapsed;
        logic [31:0] hold;
        n       = 0;
        src     = btn[1] ? SRC_SEC : SRC_DRV;
        is_open = ~btn[0];
        if (int'(btn) >= NUM_BUTTONS) begin
            return;
        end
        elapsed = tick - last_edge_tick[btn];
        if (elapsed < {16'd0, debounce_cfg}) begin
            return;
        end
        last_edge_tick[btn] = tick;
        edges_kept++;
        if (btn <= BTN_SEC_CLOSE) begin
            if (pressed) begin
                press_tick[btn[1:0]] = tick;
                held[btn[1:0]]       = 1'b1;
                if (|(held & OPEN_MASK) && |(held & CLOSE_MASK)) begin
                    evs[n] = '{EV_CONFLICT, SRC_NONE, tick, 1'b0};
                    n++;
                end
                evs[n] = '{is_open ? EV_OPEN_PRESS : EV_CLOSE_PRESS, src, tick, 1'b0};
                n++;
            end else begin
                hold           = tick - press_tick[btn[1:0]];
                held[btn[1:0]] = 1'b0;
                evs[n] = '{is_open ? EV_OPEN_REL : EV_CLOSE_REL, src, tick, 1'b0};
                n++;
                if (hold <= {16'd0, one_touch_cfg}) begin
                    evs[n] = '{is_open ? EV_OPEN_AUTO : EV_CLOSE_AUTO, src, tick, 1'b0};
                    n++;
                end
            end
        end else if (pressed && btn <= BTN_OBSTACLE) begin
            case (btn)
                BTN_LIM_OPEN:   evs[n] = '{EV_LIM_OPEN, SRC_NONE, tick, 1'b0};
                BTN_LIM_CLOSED: evs[n] = '{EV_LIM_CLOSED, SRC_NONE, tick, 1'b0};
                default:        evs[n] = '{EV_OBSTACLE, SRC_NONE, tick, 1'b0};
            endcase
            n++;
        end
        if (n > 0) begin
            evs[n-1].last_of_run = 1'b1;
        end
        for (int i = 0; i < n; i++) begin
            pending_events.push_back(evs[i]);
        end
    endtask

    always @(posedge aclk) begin
        event_t want;
        if (!aresetn) begin
            for (int i = 0; i < NUM_BUTTONS; i++) begin
                last_edge_tick[i] = '0;
            end
            for (int i = 0; i < 4; i++) begin
                press_tick[i] = '0;
            end
            held          = '0;
            debounce_cfg  = DEBOUNCE_RESET;
            one_touch_cfg = ONE_TOUCH_RESET;
            pending_events.delete();
        end else begin
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    CFG_DEBOUNCE:  debounce_cfg  = cfg_data;
                    CFG_ONE_TOUCH: one_touch_cfg = cfg_data;
                    default: ;
                endcase
            end
            if (s_valid && s_ready) begin
                classify_edge(s_button, s_asserted, s_tick);
            end
            if (m_valid && m_ready) begin
                if (pending_events.size() == 0) begin
                    report_mismatch($sformatf("unexpected event code %0d tick 0x%08h",
                                              m_event_code, m_event_tick));
                end else begin
                    want = pending_events.pop_front();
                    if (m_event_code !== want.event_code)
                        report_mismatch($sformatf("event %0d: code %0d, want %0d",
                                        events_checked, m_event_code, want.event_code));
                    if (m_event_source !== want.event_source)
                        report_mismatch($sformatf("event %0d: source %0d, want %0d",
                                        events_checked, m_event_source, want.event_source));
                    if (m_event_tick !== want.event_tick)
                        report_mismatch($sformatf("event %0d: tick 0x%08h, want 0x%08h",
                                        events_checked, m_event_tick, want.event_tick));
                    if (m_last_of_run !== want.last_of_run)
                        report_mismatch($sformatf("event %0d: last %0b, want %0b",
                                        events_checked, m_last_of_run, want.last_of_run));
                end
                events_checked++;
            end
        end
        events_due = pending_events.size();
    end

endmodule

`default_nettype wire

### tb/sv/tb_button_debounce_press_classifier.sv
// ----------------------------------------------------------------------------
// tb_button_debounce_press_classifier
// Edge stimulus, register settings and verdict for the press classifier.
// ----------------------------------------------------------------------------
// A short directed run covers the early-edge, bounce, wrap, conflict, release
// without press and limit cases, then random press/release sequences, bounce
// bursts and noise run under five register settings with random gaps and
// stalls. The checker beside the block predicts and compares every event.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_button_debounce_press_classifier;
    import bdpc_pkg::*;

    localparam int          CYCLE_LIMIT  = 200000;
    localparam int          RANDOM_ITEMS = 1800;
    localparam int          PHASES       = 5;
    localparam int          DRAIN_CYCLES = 6;
    localparam logic [31:0] WRAP_START   = 32'hFFFF_FC00;
    localparam logic [2:0]  BTN_UNUSED   = 3'd7;

    logic                 aclk;
    logic                 aresetn;
    logic                 s_valid;
    logic                 s_ready;
    logic [2:0]           s_button;
    logic                 s_asserted;
    logic [31:0]          s_tick;
    logic                 m_valid;
    logic                 m_ready;
    logic [3:0]           m_event_code;
    logic [1:0]           m_event_source;
    logic [31:0]          m_event_tick;
    logic                 m_last_of_run;
    logic                 cfg_valid;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [15:0]          cfg_data;

    int fail_count;
    int events_due;
    int events_checked;
    int edges_kept;

    int          cycle_count  = 0;
    int          edges_driven = 0;
    int          tx_max_gap   = 3;
    int          rx_max_stall = 3;
    logic [31:0] cur_tick;
    logic [15:0] debounce_now  = DEBOUNCE_RESET;
    logic [15:0] one_touch_now = ONE_TOUCH_RESET;

    button_debounce_press_classifier DUT (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_button       (s_button),
        .s_asserted     (s_asserted),
        .s_tick         (s_tick),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_event_code   (m_event_code),
        .m_event_source (m_event_source),
        .m_event_tick   (m_event_tick),
        .m_last_of_run  (m_last_of_run),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data)
    );

    bdpc_event_checker u_checker (.*);

    initial aclk = 1'b0;
    always #10 aclk = ~aclk;

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d events outstanding",
                     cycle_count, events_due);
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    // result side: random stall before each event
    initial begin
        int stall;
        m_ready = 1'b0;
        @(negedge aclk);
        while (!aresetn) @(negedge aclk);
        forever begin
            stall = $urandom_range(0, rx_max_stall);
            if (stall > 0) begin
                m_ready <= 1'b0;
                repeat (stall) @(negedge aclk);
            end
            m_ready <= 1'b1;
            @(posedge aclk);
            while (!m_valid) @(posedge aclk);
            @(negedge aclk);
        end
    end

    // entered and left at a falling edge; valid stays high between items unless a random gap is drawn
    task automatic send_edge(input logic [2:0] b, input logic a, input logic [31:0] t);
        int gap;
        gap = $urandom_range(0, tx_max_gap);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_valid    <= 1'b1;
        s_button   <= b;
        s_asserted <= a;
        s_tick     <= t;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        @(negedge aclk);
        edges_driven++;
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [15:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        @(negedge aclk);
    endtask

    task automatic set_registers(input logic [15:0] db, input logic [15:0] ot);
        write_reg(CFG_DEBOUNCE, db);
        write_reg(CFG_ONE_TOUCH, ot);
        write_reg(CFG_IDX_W'($urandom_range(CFG_ONE_TOUCH + 1, 2**CFG_IDX_W - 1)),
                  16'($urandom()));
        cfg_valid     <= 1'b0;
        debounce_now  = db;
        one_touch_now = ot;
    endtask

    // sender holds off until the last event is out and the pipe is empty
    task automatic settle();
        s_valid <= 1'b0;
        while (events_due != 0) @(negedge aclk);
        repeat (DRAIN_CYCLES) @(negedge aclk);
    endtask

    function automatic logic [31:0] pick_hold();
        case ($urandom_range(0, 4))
            0:       return $urandom_range(0, one_touch_now);
            1:       return one_touch_now;
            2:       return one_touch_now + 1;
            3:       return one_touch_now + $urandom_range(1, 2000);
            default: return debounce_now + $urandom_range(0, one_touch_now);
        endcase
    endfunction

    task automatic advance_tick();
        cur_tick += debounce_now + 1 + $urandom_range(0, 2 * one_touch_now + 100);
    endtask

    task automatic run_scenario();
        logic [2:0] b;
        logic [2:0] b2;
        int         kind;
        kind = $urandom_range(0, 9);
        b    = 3'($urandom_range(BTN_DRV_OPEN, BTN_SEC_CLOSE));
        advance_tick();
        case (kind)
            0, 1, 2, 3, 4: begin
                send_edge(b, 1'b1, cur_tick);
                if ($urandom_range(0, 3) == 0)
                    send_edge(b, 1'($urandom_range(0, 1)),
                              cur_tick + $urandom_range(0, debounce_now));
                cur_tick += pick_hold();
                send_edge(b, 1'b0, cur_tick);
            end
            5, 6: begin
                b2 = {1'b0, 1'($urandom_range(0, 1)), ~b[0]};
                send_edge(b, 1'b1, cur_tick);
                cur_tick += $urandom_range(0, one_touch_now);
                send_edge(b2, 1'b1, cur_tick);
                cur_tick += pick_hold();
                send_edge(b, 1'b0, cur_tick);
                cur_tick += $urandom_range(0, one_touch_now);
                send_edge(b2, 1'b0, cur_tick);
            end
            7: begin
                b = 3'($urandom_range(BTN_LIM_OPEN, BTN_OBSTACLE));
                send_edge(b, 1'b1, cur_tick);
                if ($urandom_range(0, 1) == 0)
                    send_edge(b, 1'b0, cur_tick + $urandom_range(0, debounce_now));
                advance_tick();
                send_edge(b, 1'b0, cur_tick);
            end
            8: begin
                send_edge(3'($urandom_range(0, 7)), 1'($urandom_range(0, 1)), $urandom());
            end
            default: begin
                b = 3'($urandom_range(BTN_DRV_OPEN, BTN_OBSTACLE));
                repeat ($urandom_range(2, 5)) begin
                    send_edge(b, 1'($urandom_range(0, 1)), cur_tick);
                    cur_tick += $urandom_range(0, debounce_now / 2 + 1);
                end
            end
        endcase
    endtask

    task automatic run_directed();
        send_edge(BTN_DRV_OPEN, 1'b1, 32'd5);          // early edge after reset
        send_edge(BTN_UNUSED, 1'b1, 32'd1000);         // no such button
        send_edge(BTN_DRV_OPEN, 1'b1, 32'd100);
        send_edge(BTN_DRV_OPEN, 1'b0, 32'd110);        // bounce
        send_edge(BTN_DRV_OPEN, 1'b0, 32'd350);        // hold right at the limit
        send_edge(BTN_DRV_CLOSE, 1'b0, 32'd1000);      // release, never pressed
        send_edge(BTN_SEC_OPEN, 1'b0, 32'd200);
        send_edge(BTN_SEC_CLOSE, 1'b1, 32'd400);
        send_edge(BTN_SEC_OPEN, 1'b1, 32'd420);        // open and close held
        send_edge(BTN_DRV_CLOSE, 1'b1, 32'd1430);
        send_edge(BTN_SEC_CLOSE, 1'b0, 32'd651);       // one past the limit
        send_edge(BTN_SEC_OPEN, 1'b0, 32'd700);
        send_edge(BTN_DRV_CLOSE, 1'b0, 32'd1500);
        send_edge(BTN_LIM_OPEN, 1'b1, 32'd500);
        send_edge(BTN_LIM_OPEN, 1'b0, 32'd600);
        send_edge(BTN_LIM_CLOSED, 1'b1, 32'd700);
        send_edge(BTN_LIM_CLOSED, 1'b0, 32'd800);
        send_edge(BTN_OBSTACLE, 1'b1, 32'd900);
        send_edge(BTN_OBSTACLE, 1'b0, 32'd1000);
        send_edge(BTN_DRV_OPEN, 1'b1, 32'hFFFF_FFF0);  // hold across the wrap
        send_edge(BTN_DRV_OPEN, 1'b0, 32'h0000_0010);
        send_edge(BTN_SEC_CLOSE, 1'b1, 32'hFFFF_FFFF);
        send_edge(BTN_SEC_CLOSE, 1'b0, 32'h0000_0040);
    endtask

    initial begin
        int phase_end;
        aresetn    = 1'b0;
        s_valid    = 1'b0;
        s_button   = '0;
        s_asserted = 1'b0;
        s_tick     = '0;
        cfg_valid  = 1'b0;
        cfg_index  = '0;
        cfg_data   = '0;
        cur_tick   = '0;
        repeat (8) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        run_directed();
        settle();

        for (int p = 0; p < PHASES; p++) begin
            case (p)
                0: begin
                    tx_max_gap   = 3;
                    rx_max_stall = 3;
                end
                1: begin
                    set_registers(16'd0, 16'd0);
                    tx_max_gap   = 0;
                    rx_max_stall = 0;
                end
                2: begin
                    set_registers(16'hFFFF, 16'hFFFF);
                    tx_max_gap   = 3;
                    rx_max_stall = 0;
                end
                3: begin
                    set_registers(16'($urandom_range(1, 100)), 16'($urandom_range(0, 1000)));
                    tx_max_gap   = 0;
                    rx_max_stall = 3;
                end
                default: begin
                    set_registers(16'($urandom()), 16'($urandom()));
                    tx_max_gap   = 3;
                    rx_max_stall = 3;
                end
            endcase
            cur_tick  = (p == 0) ? WRAP_START : $urandom();
            phase_end = edges_kept + RANDOM_ITEMS / PHASES;
            while (edges_kept < phase_end) run_scenario();
            settle();
        end

        $display("Drove %0d button edges, %0d past debounce, %0d events compared.",
                 edges_driven, edges_kept, events_checked);
        $display("Settings: reset defaults, all zero, full scale and two random pairs.");
        if (fail_count == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule

`default_nettype wire

### sim.f
sv/bdpc_pkg.sv
sv/bdpc_classify.sv
sv/bdpc_out_buf.sv
sv/button_debounce_press_classifier.sv
tb/sv/bdpc_event_checker.sv
tb/sv/tb_button_debounce_press_classifier.sv
